/* hdl/lptw_pkg.sv */
// ---------------------------------------------------------------------------
// lptw_pkg
// Shared types, constants and the CORDIC arctangent table for the lidar
// point to world box filter.
// ---------------------------------------------------------------------------
package lptw_pkg;

  localparam int MAX_SAMPLES  = 4096;
  localparam int IDX_W        = $clog2(MAX_SAMPLES);
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;
  localparam int ANG_W        = 16;
  localparam int CORD_W       = 34;
  localparam int MUL_A_W      = 17;
  localparam int MUL_B_W      = 34;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int PT_W         = 33;
  localparam int ACC_W        = 53;
  localparam int WC_W         = ACC_W - 28;
  localparam int MSTEP_W      = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  localparam logic [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_XYZ  = 3'd5;

  // multiplier schedule: one product per step, consumed on the next step
  localparam logic [MSTEP_W-1:0] MS_RC   = 4'd0;
  localparam logic [MSTEP_W-1:0] MS_RS   = 4'd1;
  localparam logic [MSTEP_W-1:0] MS_XPX  = 4'd2;
  localparam logic [MSTEP_W-1:0] MS_XPY  = 4'd3;
  localparam logic [MSTEP_W-1:0] MS_YPX  = 4'd4;
  localparam logic [MSTEP_W-1:0] MS_YPY  = 4'd5;
  localparam logic [MSTEP_W-1:0] MS_ZPX  = 4'd6;
  localparam logic [MSTEP_W-1:0] MS_ZPY  = 4'd7;
  localparam logic [MSTEP_W-1:0] MS_LAST = 4'd8;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        scan_start;
    logic        scan_last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] world_x_mm;
    logic signed [15:0] world_y_mm;
    logic signed [15:0] world_z_mm;
    logic               in_box;
    logic               end_of_scan;
  } out_word_t;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    logic [31:0] rot_row_x;
    logic [31:0] rot_row_y;
    logic [31:0] rot_row_z;
    logic [47:0] offset_xyz;
  } cfg_regs_t;

  typedef struct packed {
    logic               load;
    logic               cord_en;
    logic [STEP_W-1:0]  cord_i;
    logic               mul_en;
    logic [MSTEP_W-1:0] mul_step;
    logic               out_load;
  } lptw_cmd_t;

  typedef struct packed {
    logic out_free;
  } lptw_stat_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/lidar_point_to_world_box_filter.sv */
// ---------------------------------------------------------------------------
// lidar_point_to_world_box_filter
// Lidar range sample to world-frame point with obstacle box flag.
// ---------------------------------------------------------------------------
// Usage:
//  in_*  : one range word per sample; scan_start restarts the sample index.
//  out_* : one result word per input word, in order.
//  cfg_* : register writes by index, always ready; write only while idle.
//  An accepted word runs 16 CORDIC iterations (one per cycle) and then
//  nine steps through the single shared 17x34 multiplier; the result is
//  then loaded into the output register. in_ready returns the cycle after
//  the result is loaded, so a word is accepted only once the last is done.
//  The result sits in an output register; a stalled receiver holds it
//  while the next word is accepted and processed. The block then waits
//  with its finished point until the register frees.
//  Reset (rst_n low, synchronous) clears the sample index, the sequencer,
//  out_valid and loads the default registers (x row 1.0/1.0, y row 0/1.0, z row zero).
// ---------------------------------------------------------------------------
module lidar_point_to_world_box_filter import lptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t  cfg_r;
  lptw_cmd_t  cmd;
  lptw_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_start <= '0;
      cfg_r.angle_step  <= '0;
      cfg_r.rot_row_x   <= 32'h40004000;
      cfg_r.rot_row_y   <= 32'h00004000;
      cfg_r.rot_row_z   <= '0;
      cfg_r.offset_xyz  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ANGLE_START: cfg_r.angle_start <= cfg_data[15:0];
        CFG_ANGLE_STEP:  cfg_r.angle_step  <= cfg_data[15:0];
        CFG_ROT_ROW_X:   cfg_r.rot_row_x   <= cfg_data[31:0];
        CFG_ROT_ROW_Y:   cfg_r.rot_row_y   <= cfg_data[31:0];
        CFG_ROT_ROW_Z:   cfg_r.rot_row_z   <= cfg_data[31:0];
        CFG_OFFSET_XYZ:  cfg_r.offset_xyz  <= cfg_data;
        default: ;
      endcase
    end
  end

  lptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lptw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while another is in flight");

  // a new result is only loaded while the input side is closed
  a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !in_ready)
    else $error("result loaded while idle");

  // result load never overwrites an untaken word
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("output word overwritten");

endmodule

/* hdl/lptw_ctrl.sv */
// ---------------------------------------------------------------------------
// lptw_ctrl
// Sequencer: accept, CORDIC iterations, multiply schedule, result hand-off.
// ---------------------------------------------------------------------------
module lptw_ctrl import lptw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lptw_stat_t stat,
  output lptw_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CORD = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.cord_i   = cnt_r;
    cmd.mul_step = cnt_r[MSTEP_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CORD;
        end
      end
      ST_CORD: begin
        cmd.cord_en = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (cnt_r[MSTEP_W-1:0] == MS_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* hdl/lptw_dp.sv */
// ---------------------------------------------------------------------------
// lptw_dp
// Datapath: sample index, CORDIC rotator, shared multiplier, world transform,
// box test and output register.
// ---------------------------------------------------------------------------
module lptw_dp import lptw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lptw_cmd_t  cmd,
  output lptw_stat_t stat,
  input  cfg_regs_t  cfg,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  logic [IDX_W-1:0]         sample_index_r;
  logic [IDX_W-1:0]         idx;
  logic [15:0]              range_r;
  logic                     last_r;
  logic                     flip_r;
  logic signed [CORD_W-1:0] x_r, y_r, z_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [PT_W-1:0]   px_r, py_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [WC_W-1:0]   wx_r, wy_r, wz_r;
  logic                     out_valid_r;
  out_word_t                out_r;

  // angle and fold into [-1/4, +1/4) turn
  logic [ANG_W-1:0] ang, angf;
  logic             flip;
  always_comb begin
    idx  = in_data.scan_start ? '0 : sample_index_r;
    ang  = cfg.angle_start + ANG_W'(cfg.angle_step * idx);
    flip = ang[14] ^ ang[15];
    angf = flip ? (ang + 16'h8000) : ang;
  end

  // one CORDIC rotation step
  logic signed [CORD_W-1:0] xs, ys, at;
  always_comb begin
    xs = x_r >>> cmd.cord_i;
    ys = y_r >>> cmd.cord_i;
    at = signed'({2'b00, atan_turn(cmd.cord_i)});
  end

  // shared multiplier operand select
  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic signed [MUL_B_W-1:0] pxe, pye;
  always_comb begin
    pxe = MUL_B_W'(px_r);
    pye = MUL_B_W'(py_r);
    ma  = '0;
    mb  = '0;
    unique case (cmd.mul_step)
      MS_RC:  begin ma = signed'({1'b0, range_r}); mb = flip_r ? -x_r : x_r; end
      MS_RS:  begin ma = signed'({1'b0, range_r}); mb = flip_r ? -y_r : y_r; end
      MS_XPX: begin ma = MUL_A_W'(signed'(cfg.rot_row_x[31:16])); mb = pxe; end
      MS_XPY: begin ma = MUL_A_W'(signed'(cfg.rot_row_x[15:0]));  mb = pye; end
      MS_YPX: begin ma = MUL_A_W'(signed'(cfg.rot_row_y[31:16])); mb = pxe; end
      MS_YPY: begin ma = MUL_A_W'(signed'(cfg.rot_row_y[15:0]));  mb = pye; end
      MS_ZPX: begin ma = MUL_A_W'(signed'(cfg.rot_row_z[31:16])); mb = pxe; end
      MS_ZPY: begin ma = MUL_A_W'(signed'(cfg.rot_row_z[15:0]));  mb = pye; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // row sum plus offset, rounded to mm
  function automatic logic signed [WC_W-1:0] coord(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p,
    input logic [15:0]              off
  );
    logic signed [ACC_W-1:0] s;
    s = acc + ACC_W'(p) + (ACC_W'(signed'(off)) <<< 28)
        + (ACC_W'(1) <<< 27);
    return WC_W'(s >>> 28);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [WC_W-1:0] v);
    logic signed [15:0] r;
    if (v > WC_W'(32767))        r = 16'sh7FFF;
    else if (v < -WC_W'(32768))  r = 16'sh8000;
    else                         r = v[15:0];
    return r;
  endfunction

  logic signed [PROD_W-1:0] pr;
  always_comb pr = p_r + (PROD_W'(1) <<< 15);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      range_r <= in_data.range_mm;
      last_r  <= in_data.scan_last;
      flip_r  <= flip;
      x_r     <= signed'(CORDIC_GAIN);
      y_r     <= '0;
      z_r     <= signed'({{2{angf[15]}}, angf, 16'h0000});
    end
    if (cmd.cord_en) begin
      if (!z_r[CORD_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.mul_en) begin
      p_r <= ma * mb;
      unique case (cmd.mul_step)
        MS_RS:  px_r <= PT_W'(pr >>> 16);
        MS_XPX: py_r <= PT_W'(pr >>> 16);
        MS_XPY, MS_YPY, MS_ZPY: acc_r <= ACC_W'(p_r);
        MS_YPX: wx_r <= coord(acc_r, p_r, cfg.offset_xyz[47:32]);
        MS_ZPX: wy_r <= coord(acc_r, p_r, cfg.offset_xyz[31:16]);
        MS_LAST: wz_r <= coord(acc_r, p_r, cfg.offset_xyz[15:0]);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_r <= out_word_t'{
        world_x_mm:  sat16(wx_r),
        world_y_mm:  sat16(wy_r),
        world_z_mm:  sat16(wz_r),
        in_box:      (wz_r >= WC_W'(300)) && (wz_r <= WC_W'(2000)) &&
                     (wx_r >= -WC_W'(10000)) && (wx_r <= WC_W'(10000)) &&
                     (wy_r >= -WC_W'(10000)) && (wy_r <= WC_W'(10000)),
        end_of_scan: last_r
      };
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        // index wraps naturally at MAX_SAMPLES
        sample_index_r <= in_data.scan_last ? '0 : idx + 1'b1;
      end
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule
